### design/bsr_pkg.sv
package bsr_pkg;

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        STAT_UNCHANGED = 3'd0,
        STAT_NEW       = 3'd1,
        STAT_UPDATED   = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_QRY_HIT   = 3'd4,
        STAT_QRY_MISS  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPEND,
        ST_QWAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        req_type;
        logic [47:0] bssid;
        logic [3:0]  frame_subtype;
        logic [63:0] frame_digest;
        logic [9:0]  query_index;
    } s_item_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  entry_index;
        logic [15:0] entry_revision;
        logic [47:0] entry_bssid;
        logic [3:0]  entry_subtype;
        logic [63:0] entry_digest;
        logic [6:0]  filled_count;
    } m_item_t;

    // one table row as held in the ram
    typedef struct packed {
        logic [47:0] key;
        logic [3:0]  subtype;
        logic [63:0] digest;
        logic [15:0] revision;
    } entry_row_t;

    // compare unit verdict
    typedef struct packed {
        logic key_hit;
        logic content_same;
    } cmp_t;

endpackage

### design/bsr_ram.sv
module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/bsr_cmp.sv
module bsr_cmp
    import bsr_pkg::*;
(
    input  entry_row_t row,
    input  s_item_t    req,
    output cmp_t       verdict
);

    // key match and content match for the row just read
    always_comb begin
        verdict.key_hit      = (row.key == req.bssid);
        verdict.content_same = (row.subtype == req.frame_subtype) &&
                               (row.digest == req.frame_digest);
    end

endmodule

### design/bsr_seq.sv
module bsr_seq
    import bsr_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  s_item_t s_item,
    output logic    res_valid,
    input  logic    res_ready,
    output m_item_t res_item
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int QIDX_W = 10;
    localparam int CMP_W  = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;

    state_t     state_reg, state_next;
    s_item_t    req_reg, req_next;
    m_item_t    res_reg, res_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_row_t       rd_row;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_row_t       wr_row;
    cmp_t             verdict;

    logic [CNT_W-1:0]   used_inc;
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W+6:0]   fill_cur_w, fill_inc_w;
    logic [IDX_W+5:0]   idx_w, app_w;
    logic [6:0]         fill_cur, fill_inc;
    logic [5:0]         idx6, app6;
    logic               q_hit, more, tbl_full, tbl_empty;

    bsr_ram #(
        .WIDTH($bits(entry_row_t)),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_row)
    );

    bsr_cmp u_cmp (
        .row     (rd_row),
        .req     (req_reg),
        .verdict (verdict)
    );

    assign used_inc   = used_reg + CNT_W'(1);
    assign idx_inc    = CNT_W'(idx_reg) + CNT_W'(1);
    assign fill_cur_w = (CNT_W+7)'(used_reg);
    assign fill_inc_w = (CNT_W+7)'(used_inc);
    assign fill_cur   = fill_cur_w[6:0];
    assign fill_inc   = fill_inc_w[6:0];
    assign idx_w      = (IDX_W+6)'(idx_reg);
    assign app_w      = (IDX_W+6)'(used_reg[IDX_W-1:0]);
    assign idx6       = idx_w[5:0];
    assign app6       = app_w[5:0];
    assign q_hit      = CMP_W'(s_item.query_index) < CMP_W'(used_reg);
    assign more       = idx_inc < used_reg;
    assign tbl_full   = (used_reg == CNT_W'(TABLE_DEPTH));
    assign tbl_empty  = (used_reg == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_item.req_type == REQ_QUERY) begin
                        state_next = q_hit ? ST_QWAIT : ST_EMIT;
                    end else begin
                        state_next = tbl_empty ? ST_APPEND : ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (verdict.key_hit) begin
                    state_next = ST_EMIT;
                end else if (!more) begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: state_next = ST_EMIT;
            ST_QWAIT:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_EMIT);
        rd_en     = 1'b0;
        rd_addr   = idx_reg;
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_row    = '{key: rd_row.key, subtype: req_reg.frame_subtype,
                      digest: req_reg.frame_digest,
                      revision: rd_row.revision + 16'd1};
        req_next  = req_reg;
        res_next  = res_reg;
        used_next = used_reg;
        idx_next  = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_item;
                    if (s_item.req_type == REQ_QUERY) begin
                        if (q_hit) begin
                            rd_en   = 1'b1;
                            rd_addr = s_item.query_index[IDX_W-1:0];
                        end else begin
                            res_next = '{status: STAT_QRY_MISS,
                                         entry_index: s_item.query_index[5:0],
                                         entry_revision: '0, entry_bssid: '0,
                                         entry_subtype: '0, entry_digest: '0,
                                         filled_count: fill_cur};
                        end
                    end else if (!tbl_empty) begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_next = '0;
                    end
                end
            end
            ST_SEARCH: begin
                if (verdict.key_hit) begin
                    if (verdict.content_same) begin
                        res_next = '{status: STAT_UNCHANGED, entry_index: idx6,
                                     entry_revision: rd_row.revision,
                                     entry_bssid: rd_row.key,
                                     entry_subtype: rd_row.subtype,
                                     entry_digest: rd_row.digest,
                                     filled_count: fill_cur};
                    end else begin
                        wr_en    = 1'b1;
                        res_next = '{status: STAT_UPDATED, entry_index: idx6,
                                     entry_revision: wr_row.revision,
                                     entry_bssid: wr_row.key,
                                     entry_subtype: wr_row.subtype,
                                     entry_digest: wr_row.digest,
                                     filled_count: fill_cur};
                    end
                end else if (more) begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc[IDX_W-1:0];
                    idx_next = idx_inc[IDX_W-1:0];
                end
            end
            ST_APPEND: begin
                if (tbl_full) begin
                    res_next = '{status: STAT_FULL, entry_index: '0,
                                 entry_revision: '0, entry_bssid: '0,
                                 entry_subtype: '0, entry_digest: '0,
                                 filled_count: fill_cur};
                end else begin
                    // a fresh slot is written whole, its revision goes to one
                    wr_en     = 1'b1;
                    wr_addr   = used_reg[IDX_W-1:0];
                    wr_row    = '{key: req_reg.bssid, subtype: req_reg.frame_subtype,
                                  digest: req_reg.frame_digest, revision: 16'd1};
                    used_next = used_inc;
                    res_next  = '{status: STAT_NEW, entry_index: app6,
                                  entry_revision: 16'd1,
                                  entry_bssid: req_reg.bssid,
                                  entry_subtype: req_reg.frame_subtype,
                                  entry_digest: req_reg.frame_digest,
                                  filled_count: fill_inc};
                end
            end
            ST_QWAIT: begin
                res_next = '{status: STAT_QRY_HIT,
                             entry_index: req_reg.query_index[5:0],
                             entry_revision: rd_row.revision,
                             entry_bssid: rd_row.key,
                             entry_subtype: rd_row.subtype,
                             entry_digest: rd_row.digest,
                             filled_count: fill_cur};
            end
            ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        res_reg <= res_next;
        idx_reg <= idx_next;
    end

    assign res_item = res_reg;

endmodule

### design/bssid_registry_with_revisions.sv
// channel   dir   handshake           payload
// s_        in    s_valid / s_ready   s_item   (s_item_t: request item)
// m_        out   m_valid / m_ready   m_item   (m_item_t: result item)
//
// a query miss goes from accept straight to its result; a hit first waits for one ram read before m_valid
// a record scans the filled entries one per cycle through the single ram
//   read port and the 48-bit key compare, stopping at the first key hit
// reset is synchronous active low; clears state and fill count, no ram sweep
// s_ready is high only while the sequencer is idle
// the output register holds a finished item while m_ready is low, so the
//   next item can be taken meanwhile
module bssid_registry_with_revisions
    import bsr_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  s_item_t s_item,
    output logic    m_valid,
    input  logic    m_ready,
    output m_item_t m_item
);

    logic    res_valid;
    logic    res_ready;
    m_item_t res_item;

    logic    m_valid_reg, m_valid_next;
    m_item_t m_item_reg, m_item_next;

    // search / insert / query sequencer with the table ram
    bsr_seq #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // output stage: loads when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_item_next  = res_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // sequencer never takes a request while holding a finished item
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_ready)
        else $error("request taken while result pending");

    // a request is never followed by another in the next cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("back to back accept");

    // a stalled handoff keeps its item
    a_handoff_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("handoff item changed while stalled");

    // a freshly appended entry always carries revision one
    a_new_rev_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == STAT_NEW |-> m_item.entry_revision == 16'd1)
        else $error("new entry with revision other than one");

endmodule
